// File: design/flv_avc_to_annexb_converter_unit_defines.svh
// Assertion macros used by the checker file flvac_checker.sv.
`ifndef FLV_AVC_TO_ANNEXB_CONVERTER_UNIT_DEFINES_SVH
`define FLV_AVC_TO_ANNEXB_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define FLVAC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define FLVAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/flvac_pkg.sv
`default_nettype none
package flvac_pkg;

  localparam int LENGTH_BITS = 32;

  localparam logic [2:0] PREFIX_RESET  = 3'd4;
  localparam logic [2:0] HDR_LEN       = 3'd5;
  localparam logic [2:0] CFG_SKIP_LEN  = 3'd4;
  localparam logic [2:0] SET_LEN_BYTES = 3'd2;
  localparam logic [2:0] START_CODE_N  = 3'd4;
  localparam logic [7:0] PKT_SEQ_HDR   = 8'h00;
  localparam logic [7:0] PKT_NALU      = 8'h01;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_PKT_TYPE  = 2'd1,
    ERR_TRUNCATED = 2'd2
  } flvac_err_t;

  typedef enum logic [10:0] {
    PH_HDR       = 11'b00000000001,
    PH_SEQ_HDR   = 11'b00000000010,
    PH_NALU_HDR  = 11'b00000000100,
    PH_CFG_SKIP  = 11'b00000001000,
    PH_CFG_LEN   = 11'b00000010000,
    PH_SET_COUNT = 11'b00000100000,
    PH_SET_LEN   = 11'b00001000000,
    PH_SET_DATA  = 11'b00010000000,
    PH_NALU_LEN  = 11'b00100000000,
    PH_NALU_DATA = 11'b01000000000,
    PH_DISCARD   = 11'b10000000000
  } flvac_phase_t;

  typedef struct packed {
    logic       start_code;
    logic       data;
    logic [7:0] data_byte;
    logic       done;
    flvac_err_t err;
  } flvac_res_t;

endpackage
`default_nettype wire

// File: design/flvac_parser.sv
`default_nettype none
module flvac_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [7:0]        in_byte,
  input  wire logic              tag_end,
  output flvac_pkg::flvac_res_t  res
);
  import flvac_pkg::*;

  flvac_phase_t            phase, phase_next;
  logic [2:0]              field_count, field_count_next;
  logic [2:0]              prefix_size, prefix_size_next;
  logic [LENGTH_BITS-1:0]  length_accum, length_accum_next;
  logic [LENGTH_BITS-1:0]  bytes_left, bytes_left_next;
  logic [4:0]              sets_left, sets_left_next;
  logic                    doing_pps, doing_pps_next;
  flvac_err_t              tag_error, tag_error_next;

  logic [2:0]              fc_inc;
  logic [15:0]             set_len;
  logic [LENGTH_BITS-1:0]  nalu_len;
  logic [LENGTH_BITS-1:0]  bl_dec;
  logic [4:0]              sets_dec;
  logic                    set_fin;
  flvac_err_t              err;

  assign fc_inc   = field_count + 3'd1;
  assign set_len  = {length_accum[7:0], in_byte};
  assign nalu_len = {length_accum[LENGTH_BITS-9:0], in_byte};
  assign bl_dec   = bytes_left - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  assign sets_dec = sets_left - 5'd1;

  always_comb begin
    phase_next        = phase;
    field_count_next  = field_count;
    prefix_size_next  = prefix_size;
    length_accum_next = length_accum;
    bytes_left_next   = bytes_left;
    sets_left_next    = sets_left;
    doing_pps_next    = doing_pps;
    tag_error_next    = tag_error;
    set_fin           = 1'b0;
    err               = ERR_NONE;
    res               = '0;
    res.data_byte     = in_byte;

    unique case (phase)
      PH_HDR: begin
        if (field_count == 3'd1) begin
          if (in_byte == PKT_SEQ_HDR) begin
            phase_next = PH_SEQ_HDR;
          end else if (in_byte == PKT_NALU) begin
            phase_next = PH_NALU_HDR;
          end else begin
            phase_next     = PH_DISCARD;
            tag_error_next = ERR_PKT_TYPE;
          end
        end
        field_count_next = fc_inc;
      end
      PH_SEQ_HDR, PH_NALU_HDR: begin
        field_count_next = fc_inc;
        if (fc_inc >= HDR_LEN) begin
          phase_next        = (phase == PH_SEQ_HDR) ? PH_CFG_SKIP : PH_NALU_LEN;
          field_count_next  = 3'd0;
          length_accum_next = '0;
        end
      end
      PH_CFG_SKIP: begin
        field_count_next = fc_inc;
        if (fc_inc >= CFG_SKIP_LEN) begin
          phase_next       = PH_CFG_LEN;
          field_count_next = 3'd0;
        end
      end
      PH_CFG_LEN: begin
        prefix_size_next = {1'b0, in_byte[1:0]} + 3'd1;
        phase_next       = PH_SET_COUNT;
        doing_pps_next   = 1'b0;
      end
      PH_SET_COUNT: begin
        sets_left_next = in_byte[4:0];
        if (in_byte[4:0] != 5'd0) begin
          phase_next        = PH_SET_LEN;
          field_count_next  = 3'd0;
          length_accum_next = '0;
        end else if (!doing_pps) begin
          doing_pps_next = 1'b1;
        end else begin
          phase_next = PH_DISCARD;
        end
      end
      PH_SET_LEN: begin
        length_accum_next = {{(LENGTH_BITS-16){1'b0}}, set_len};
        field_count_next  = fc_inc;
        if (fc_inc >= SET_LEN_BYTES) begin
          res.start_code   = 1'b1;
          bytes_left_next  = {{(LENGTH_BITS-16){1'b0}}, set_len};
          field_count_next = 3'd0;
          if (set_len == 16'd0) begin
            set_fin = 1'b1;
          end else begin
            phase_next = PH_SET_DATA;
          end
        end
      end
      PH_SET_DATA: begin
        res.data        = 1'b1;
        bytes_left_next = bl_dec;
        if (bl_dec == '0) begin
          set_fin = 1'b1;
        end
      end
      PH_NALU_LEN: begin
        length_accum_next = nalu_len;
        field_count_next  = fc_inc;
        if (fc_inc >= prefix_size) begin
          res.start_code    = 1'b1;
          bytes_left_next   = nalu_len;
          field_count_next  = 3'd0;
          length_accum_next = '0;
          if (nalu_len != '0) begin
            phase_next = PH_NALU_DATA;
          end
        end
      end
      PH_NALU_DATA: begin
        res.data        = 1'b1;
        bytes_left_next = bl_dec;
        if (bl_dec == '0) begin
          phase_next        = PH_NALU_LEN;
          field_count_next  = 3'd0;
          length_accum_next = '0;
        end
      end
      default: begin
        phase_next = PH_DISCARD;
      end
    endcase

    if (set_fin) begin
      sets_left_next = sets_dec;
      if (sets_dec != 5'd0) begin
        phase_next        = PH_SET_LEN;
        field_count_next  = 3'd0;
        length_accum_next = '0;
      end else if (!doing_pps) begin
        doing_pps_next = 1'b1;
        phase_next     = PH_SET_COUNT;
      end else begin
        phase_next = PH_DISCARD;
      end
    end

    if (tag_end) begin
      err = tag_error_next;
      if (err == ERR_NONE) begin
        case (phase_next) inside
          PH_HDR, PH_SEQ_HDR, PH_NALU_HDR, PH_SET_DATA, PH_NALU_DATA: begin
            err = ERR_TRUNCATED;
          end
          PH_SET_LEN, PH_NALU_LEN: begin
            if (field_count_next != 3'd0) begin
              err = ERR_TRUNCATED;
            end
          end
          default: begin
            err = ERR_NONE;
          end
        endcase
      end
      res.done          = 1'b1;
      res.err           = err;
      phase_next        = PH_HDR;
      field_count_next  = 3'd0;
      length_accum_next = '0;
      bytes_left_next   = '0;
      sets_left_next    = 5'd0;
      doing_pps_next    = 1'b0;
      tag_error_next    = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR;
      field_count  <= 3'd0;
      prefix_size  <= PREFIX_RESET;
      length_accum <= '0;
      bytes_left   <= '0;
      sets_left    <= 5'd0;
      doing_pps    <= 1'b0;
      tag_error    <= ERR_NONE;
    end else if (fire) begin
      phase        <= phase_next;
      field_count  <= field_count_next;
      prefix_size  <= prefix_size_next;
      length_accum <= length_accum_next;
      bytes_left   <= bytes_left_next;
      sets_left    <= sets_left_next;
      doing_pps    <= doing_pps_next;
      tag_error    <= tag_error_next;
    end
  end

endmodule
`default_nettype wire

// File: design/flvac_out.sv
`default_nettype none
module flvac_out (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  flvac_pkg::flvac_res_t  res,
  output logic                   take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   byte_valid,
  output logic                   unit_start,
  output logic                   tag_done,
  output logic [1:0]             error_code
);
  import flvac_pkg::*;

  logic [2:0]  cnt;
  logic        is_sc;
  logic        is_data;
  logic [7:0]  dbyte;
  logic        done;
  flvac_err_t  err;
  logic        load;

  assign load      = fire && (res.start_code || res.data || res.done);
  assign out_valid = (cnt != 3'd0);
  assign take      = (cnt == 3'd0) || ((cnt == 3'd1) && out_ready);

  assign out_byte   = is_sc ? {7'd0, (cnt == 3'd1)} : (is_data ? dbyte : 8'd0);
  assign byte_valid = is_sc || is_data;
  assign unit_start = is_sc && (cnt == START_CODE_N);
  assign tag_done   = done && (cnt == 3'd1);
  assign error_code = tag_done ? err : ERR_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (load) begin
      cnt <= res.start_code ? START_CODE_N : 3'd1;
    end else if (out_valid && out_ready) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_sc   <= res.start_code;
      is_data <= res.data;
      dbyte   <= res.data_byte;
      done    <= res.done;
      err     <= res.err;
    end
  end

endmodule
`default_nettype wire

// File: design/flv_avc_to_annexb_converter_unit.sv
// Output: each result is registered, appearing in the cycle after its byte is accepted.
// Throughput: one tag byte per cycle while out_ready holds; a unit length that
// completes emits a four-byte start code, holding input until its last byte goes.
// Reset: synchronous rst returns parsing to the tag header, length-prefix
// size to four bytes and empties the output register.
`default_nettype none
module flv_avc_to_annexb_converter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        tag_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             unit_start,
  output logic             tag_done,
  output logic [1:0]       error_code
);
  import flvac_pkg::*;

  flvac_res_t res;
  logic       fire;

  assign fire = in_valid && in_ready;

  flvac_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_byte (in_byte),
    .tag_end (tag_end),
    .res     (res)
  );

  flvac_out u_out (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .res        (res),
    .take       (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .unit_start (unit_start),
    .tag_done   (tag_done),
    .error_code (error_code)
  );

endmodule
`default_nettype wire

// File: design/flvac_checker.sv
`default_nettype none
`include "flv_avc_to_annexb_converter_unit_defines.svh"
module flvac_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic       unit_start,
  input wire logic       tag_done,
  input wire logic [1:0] error_code
);

  `FLVAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `FLVAC_ASSERT_NEXT(a_sc_cont, out_valid && out_ready && unit_start, out_valid && !unit_start, "start code cut short")
  `FLVAC_ASSERT_SAME(a_sc_zero, out_valid && unit_start, byte_valid && (out_byte == 8'd0), "bad start code lead byte")
  `FLVAC_ASSERT_SAME(a_marker_end, out_valid && !byte_valid, tag_done, "bare marker outside tag end")
  `FLVAC_ASSERT_SAME(a_err_end, out_valid && !tag_done, error_code == 2'd0, "error code outside tag end")

endmodule

bind flv_avc_to_annexb_converter_unit flvac_checker u_chk (.*);
`default_nettype wire

// File: test/flvac_annexb_checker.sv
module flvac_annexb_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       tag_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       byte_valid,
  input  logic       unit_start,
  input  logic       tag_done,
  input  logic [1:0] error_code,
  output int         errors,
  output int         pending,
  output int         checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import flvac_pkg::*;

  localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  flvac_phase_t phase;
  logic [2:0]   fc;
  logic [2:0]   prefix;
  logic [31:0]  accum;
  logic [31:0]  left;
  logic [4:0]   sets;
  logic         pps;
  flvac_err_t   tag_err;

  flvac_res_t   stream_due[$];

  function automatic void restart_tag();
    phase   = PH_HDR;
    fc      = '0;
    accum   = '0;
    left    = '0;
    sets    = '0;
    pps     = 1'b0;
    tag_err = ERR_NONE;
  endfunction

  function automatic void emit(input logic [7:0] b, input logic is_data, input logic is_start);
    flvac_res_t r;
    r.start_code = is_start;
    r.data       = is_data;
    r.data_byte  = b;
    r.done       = 1'b0;
    r.err        = ERR_NONE;
    stream_due.push_back(r);
  endfunction

  function automatic void emit_start_code();
    emit(8'h00, 1'b1, 1'b1);
    emit(8'h00, 1'b1, 1'b0);
    emit(8'h00, 1'b1, 1'b0);
    emit(8'h01, 1'b1, 1'b0);
  endfunction

  function automatic void next_param_set();
    sets = sets - 5'd1;
    if (sets != 0) begin
      phase = PH_SET_LEN;
      fc    = '0;
      accum = '0;
    end else if (!pps) begin
      pps   = 1'b1;
      phase = PH_SET_COUNT;
    end else begin
      phase = PH_DISCARD;
    end
  endfunction

  function automatic void parse_tag_byte(input logic [7:0] b, input logic last);
    int         n_before;
    flvac_err_t err;
    flvac_res_t r;
    n_before = stream_due.size();
    case (phase)
      PH_HDR: begin
        if (fc == 3'd1) begin
          if (b == PKT_SEQ_HDR) begin
            phase = PH_SEQ_HDR;
          end else if (b == PKT_NALU) begin
            phase = PH_NALU_HDR;
          end else begin
            phase   = PH_DISCARD;
            tag_err = ERR_PKT_TYPE;
          end
        end
        fc = fc + 3'd1;
      end
      PH_SEQ_HDR, PH_NALU_HDR: begin
        fc = fc + 3'd1;
        if (fc >= HDR_LEN) begin
          phase = (phase == PH_SEQ_HDR) ? PH_CFG_SKIP : PH_NALU_LEN;
          fc    = '0;
          accum = '0;
        end
      end
      PH_CFG_SKIP: begin
        fc = fc + 3'd1;
        if (fc >= CFG_SKIP_LEN) begin
          phase = PH_CFG_LEN;
          fc    = '0;
        end
      end
      PH_CFG_LEN: begin
        prefix = {1'b0, b[1:0]} + 3'd1;
        phase  = PH_SET_COUNT;
        pps    = 1'b0;
      end
      PH_SET_COUNT: begin
        sets = b[4:0];
        if (sets != 0) begin
          phase = PH_SET_LEN;
          fc    = '0;
          accum = '0;
        end else if (!pps) begin
          pps = 1'b1;
        end else begin
          phase = PH_DISCARD;
        end
      end
      PH_SET_LEN: begin
        accum = {16'd0, accum[7:0], b};
        fc    = fc + 3'd1;
        if (fc >= SET_LEN_BYTES) begin
          emit_start_code();
          left = accum;
          fc   = '0;
          if (left == 0) next_param_set();
          else phase = PH_SET_DATA;
        end
      end
      PH_SET_DATA: begin
        emit(b, 1'b1, 1'b0);
        left = left - 32'd1;
        if (left == 0) next_param_set();
      end
      PH_NALU_LEN: begin
        accum = ((accum << 8) | {24'd0, b}) & LEN_MASK;
        fc    = fc + 3'd1;
        if (fc >= prefix) begin
          emit_start_code();
          left  = accum;
          fc    = '0;
          accum = '0;
          if (left != 0) phase = PH_NALU_DATA;
        end
      end
      PH_NALU_DATA: begin
        emit(b, 1'b1, 1'b0);
        left = left - 32'd1;
        if (left == 0) begin
          phase = PH_NALU_LEN;
          fc    = '0;
          accum = '0;
        end
      end
      default: begin
        phase = PH_DISCARD;
      end
    endcase

    if (last) begin
      err = tag_err;
      if (err == ERR_NONE) begin
        case (phase)
          PH_HDR, PH_SEQ_HDR, PH_NALU_HDR, PH_SET_DATA, PH_NALU_DATA: begin
            err = ERR_TRUNCATED;
          end
          PH_SET_LEN, PH_NALU_LEN: begin
            if (fc != 0) err = ERR_TRUNCATED;
          end
          default: begin
          end
        endcase
      end
      if (stream_due.size() == n_before) emit(8'h00, 1'b0, 1'b0);
      r = stream_due.pop_back();
      r.done = 1'b1;
      r.err  = err;
      stream_due.push_back(r);
      restart_tag();
    end
  endfunction

  always @(posedge clk) begin
    flvac_res_t want;
    if (rst) begin
      restart_tag();
      prefix = PREFIX_RESET;
      stream_due.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        checked++;
        if (stream_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected result byte %02h valid %0b start %0b done %0b err %0d",
                     $realtime, out_byte, byte_valid, unit_start, tag_done, error_code);
          end
        end else begin
          want = stream_due.pop_front();
          if (out_byte !== want.data_byte || byte_valid !== want.data ||
              unit_start !== want.start_code || tag_done !== want.done ||
              error_code !== want.err) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result %0d expected byte %02h valid %0b start %0b done %0b err %0d",
                       $realtime, checked, want.data_byte, want.data, want.start_code,
                       want.done, want.err);
              $display("%0t: result %0d got      byte %02h valid %0b start %0b done %0b err %0d",
                       $realtime, checked, out_byte, byte_valid, unit_start, tag_done,
                       error_code);
            end
          end
        end
      end
      if (in_valid && in_ready) parse_tag_byte(in_byte, tag_end);
      pending <= stream_due.size();
    end
  end

endmodule

// File: test/flv_avc_to_annexb_converter_unit_tb.sv
module flv_avc_to_annexb_converter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import flvac_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 60;
  localparam int PHASE_BYTES  = 50;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       tag_end   = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       unit_start;
  logic       tag_done;
  logic [1:0] error_code;

  int errors;
  int pending;
  int checked;

  int cycle_cnt  = 0;
  int rx_idle    = 0;
  int tx_idle    = 0;
  logic want_hold = 1'b0;
  logic hold_off  = 1'b0;

  int tags_sent  = 0;
  int bytes_sent = 0;
  int cur_prefix = 4;
  logic [7:0] tag_q[$];

  flv_avc_to_annexb_converter_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .tag_end    (tag_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .unit_start (unit_start),
    .tag_done   (tag_done),
    .error_code (error_code)
  );

  flvac_annexb_checker annexb_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .tag_end    (tag_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .unit_start (unit_start),
    .tag_done   (tag_done),
    .error_code (error_code),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= rx_idle);
  end

  // hold the output side off long enough to back up into the input
  initial begin
    @(posedge clk iff want_hold);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    tag_end  <= last;
    @(posedge clk iff in_ready);
  endtask

  task automatic send_tag();
    for (int i = 0; i < tag_q.size(); i++) send_byte(tag_q[i], i == tag_q.size() - 1);
    tags_sent++;
    bytes_sent += tag_q.size();
    tag_q.delete();
  endtask

  task automatic push_hdr(input logic [7:0] pkt_type);
    tag_q.push_back(8'($urandom));
    tag_q.push_back(pkt_type);
    repeat (3) tag_q.push_back(8'($urandom));
  endtask

  task automatic push_len(input logic [31:0] len);
    for (int i = cur_prefix - 1; i >= 0; i--) tag_q.push_back(len[8*i +: 8]);
  endtask

  task automatic trim_to(input int keep);
    while (tag_q.size() > keep) tag_q.delete(tag_q.size() - 1);
  endtask

  task automatic maybe_cut(input int pct);
    if ($urandom_range(99) < pct && tag_q.size() > 1) trim_to($urandom_range(1, tag_q.size() - 1));
  endtask

  task automatic push_set_group();
    int count;
    int len;
    count = $urandom_range(3);
    tag_q.push_back({3'($urandom), 5'(count)});
    repeat (count) begin
      len = $urandom_range(6);
      tag_q.push_back(8'h00);
      tag_q.push_back(8'(len));
      repeat (len) tag_q.push_back(8'($urandom));
    end
  endtask

  task automatic build_seq_tag();
    logic [1:0] size_code;
    push_hdr(PKT_SEQ_HDR);
    repeat (4) tag_q.push_back(8'($urandom));
    size_code = 2'($urandom_range(3));
    tag_q.push_back({6'($urandom), size_code});
    push_set_group();
    push_set_group();
    repeat ($urandom_range(2)) tag_q.push_back(8'($urandom));
    maybe_cut(20);
    if (tag_q.size() >= 10) cur_prefix = int'(size_code) + 1;
  endtask

  task automatic build_nalu_tag();
    int units;
    int len;
    push_hdr(PKT_NALU);
    units = $urandom_range(3);
    repeat (units) begin
      len = $urandom_range(10);
      push_len(32'(len));
      repeat (len) tag_q.push_back(8'($urandom));
    end
    // oversized length, tag ends long before the unit does
    if ($urandom_range(99) < 10) begin
      push_len(32'($urandom));
      repeat ($urandom_range(3)) tag_q.push_back(8'($urandom));
    end
    maybe_cut(20);
  endtask

  task automatic build_random_tag();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      build_nalu_tag();
    end else if (pick < 70) begin
      build_seq_tag();
    end else if (pick < 82) begin
      push_hdr(8'($urandom_range(2, 255)));
      repeat ($urandom_range(4)) tag_q.push_back(8'($urandom));
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 8)) tag_q.push_back(8'($urandom));
    end else begin
      push_hdr(8'($urandom_range(1)));
      trim_to($urandom_range(1, 4));
    end
  endtask

  initial begin
    int phase_start;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    tx_idle = 25;
    rx_idle <= 62;
    @(posedge clk);

    // short tag, unknown packet type, sequence header, NAL units with an empty and a cut unit
    tag_q = '{8'h17};
    send_tag();
    tag_q = '{8'h17, 8'h07, 8'hAA};
    send_tag();
    tag_q = '{8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h64, 8'h00, 8'h1F, 8'hFC,
              8'hE1, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'hFF, 8'h55};
    send_tag();
    cur_prefix = 1;
    tag_q = '{8'h27, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h65, 8'h88, 8'h05, 8'h41};
    send_tag();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          tx_idle = 25;
          rx_idle <= 62;
          want_hold <= 1'b1;
        end
        1: begin
          tx_idle = 62;
          rx_idle <= 25;
        end
        default: begin
          tx_idle = 0;
          rx_idle <= 0;
        end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_random_tag();
        send_tag();
      end
      in_valid <= 1'b0;
      @(posedge clk iff pending == 0);
    end

    rx_idle <= 0;
    repeat (8) @(posedge clk);
    $display("%0d tags, %0d bytes fed under three idling mixes and one long output stall;",
             tags_sent, bytes_sent);
    $display("%0d stream results checked across all prefix sizes and tag error kinds", checked);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/flvac_pkg.sv
design/flvac_parser.sv
design/flvac_out.sv
design/flv_avc_to_annexb_converter_unit.sv
design/flvac_checker.sv
test/flvac_annexb_checker.sv
test/flv_avc_to_annexb_converter_unit_tb.sv
